[rtl/tpsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsp_pkg
// Shared types and constants of the triggered pin sequence player: request
// action codes, byte-code opcodes, delay scale, timer width, button slots.
// ----------------------------------------------------------------------------
package tpsp_pkg;

  // Request action codes; code 3 is unused and does nothing.
  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_PROG = 2'd1,
    ACT_LEN  = 2'd2
  } action_t;

  // Byte-code opcodes. Any other opcode behaves like a no-op.
  localparam logic [7:0] OP_HALT     = 8'd0;
  localparam logic [7:0] OP_PIN_LOW  = 8'd1;
  localparam logic [7:0] OP_PIN_HIGH = 8'd2;
  localparam logic [7:0] OP_DELAY    = 8'd3;

  // A delay operand counts seconds; the timer counts milliseconds.
  localparam int unsigned DELAY_SCALE = 1000;

  // The timer holds at most 255 * 1000 and drops at most one tick below one,
  // so it spans -65534 .. 255000.
  localparam int unsigned TIMER_W = 19;

  // Only the first eight slots have a button bit.
  localparam int unsigned BUTTON_SLOTS = 8;

endpackage

[rtl/triggered_pin_sequence_player.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triggered_pin_sequence_player
// Button-started byte-code players, one per routine slot, sharing one program
// memory and one slot state memory that a sequencer walks on every tick.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A program byte write
// completes in the accepting cycle and never raises busy. A length write
// raises busy for one cycle while the slot entry is read and written back. A
// tick raises busy while the sequencer visits the slots in order and emits one
// result per slot, each shown for exactly one cycle with out_valid high; the
// receiver cannot stall, so results must be taken as they appear. A slot that
// is idle, waiting on its timer or stopping at its length is settled from its
// slot entry alone, a HALT or no-op once its opcode is fetched, and a pin or
// delay instruction once its operand byte is fetched as well: the single read
// port of the program memory fetches the opcode and operand bytes one after
// the other. The last result of a tick appears in the cycle in which busy has
// already fallen, so the next request can be taken in that same cycle.
// ----------------------------------------------------------------------------
module triggered_pin_sequence_player
  import tpsp_pkg::*;
#(
  parameter int unsigned SLOT_COUNT    = 8,
  parameter int unsigned PROGRAM_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [2:0]  in_slot_select,
  input  logic [7:0]  in_byte_address,
  input  logic [7:0]  in_byte_value,
  input  logic [8:0]  in_length_value,
  input  logic [15:0] in_tick_ms,
  input  logic [7:0]  in_button_levels,
  // Result channel.
  output logic        out_valid,
  output logic [2:0]  out_slot_index,
  output logic        out_pin_write,
  output logic [7:0]  out_pin_number,
  output logic        out_pin_level,
  output logic        out_slot_running,
  output logic        out_last_result,
  // Configuration: routine count.
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);

  // Slot index, program address, length and counter widths.
  localparam int unsigned SW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned AW  = $clog2(SLOT_COUNT * PROGRAM_BYTES);
  localparam int unsigned LW  = $clog2(PROGRAM_BYTES + 1);
  localparam int unsigned PCW = $clog2(PROGRAM_BYTES + 2);
  // One slot entry holds {active, length, counter, timer}.
  localparam int unsigned EW  = 1 + LW + PCW + TIMER_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN_WR,
    ST_EVAL,
    ST_OP,
    ST_ARG
  } state_t;

  state_t                      state_r, state_nxt;
  logic [SW-1:0]               slot_r, slot_nxt;
  logic [15:0]                 ms_r, ms_nxt;
  logic [7:0]                  buttons_r, buttons_nxt;
  logic [3:0]                  count_r;
  logic [SW-1:0]               sel_r, sel_nxt;
  logic                        sel_ok_r, sel_ok_nxt;
  logic [LW-1:0]               len_val_r, len_val_nxt;
  logic [LW-1:0]               cur_len_r, cur_len_nxt;
  logic [PCW-1:0]              cur_pc_r, cur_pc_nxt;
  logic [7:0]                  op_r, op_nxt;
  logic                        arg_oob_r, arg_oob_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [2:0]                  out_slot_r, out_slot_nxt;
  logic                        out_wrote_r, out_wrote_nxt;
  logic [7:0]                  out_pin_r, out_pin_nxt;
  logic                        out_level_r, out_level_nxt;
  logic                        out_run_r, out_run_nxt;
  logic                        out_last_r, out_last_nxt;

  // Memory ports.
  logic                        pm_we;
  logic [AW-1:0]               pm_waddr;
  logic [AW-1:0]               pm_raddr;
  logic [7:0]                  pm_rdata;
  logic                        sm_we;
  logic [SW-1:0]               sm_waddr;
  logic [EW-1:0]               sm_wdata;
  logic [SW-1:0]               sm_raddr;
  logic [EW-1:0]               sm_rdata;

  // Fields of the slot entry just read.
  logic                        e_act;
  logic [LW-1:0]               e_len;
  logic [PCW-1:0]              e_pc;
  logic signed [TIMER_W-1:0]   e_tmr;

  // Outcome of the current slot visit, before the button start check.
  logic                        fin_en;
  logic                        fin_act;
  logic [LW-1:0]               fin_len;
  logic [PCW-1:0]              fin_pc;
  logic signed [TIMER_W-1:0]   fin_tmr;
  logic                        fin_wrote;
  logic [7:0]                  fin_pin;
  logic                        fin_level;

  logic                        accept;
  logic                        is_last;
  logic                        start_ok;
  logic [4:0]                  slot_ext;
  logic                        prog_ok;
  logic                        new_sel_ok;
  logic [7:0]                  arg_byte;
  logic signed [TIMER_W-1:0]   ms_ext;

  function automatic logic [AW-1:0] prog_addr(input logic [SW-1:0] s,
                                               input logic [PCW-1:0] pos);
    return AW'(int'(s) * PROGRAM_BYTES + int'(pos));
  endfunction

  tpsp_prog_mem #(
    .DEPTH (SLOT_COUNT * PROGRAM_BYTES),
    .AW    (AW)
  ) u_prog_mem (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (in_byte_value),
    .raddr (pm_raddr),
    .rdata (pm_rdata)
  );

  tpsp_slot_mem #(
    .DEPTH (SLOT_COUNT),
    .AW    (SW),
    .WIDTH (EW)
  ) u_slot_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .raddr (sm_raddr),
    .rdata (sm_rdata)
  );

  assign e_act = sm_rdata[EW-1];
  assign e_len = sm_rdata[EW-2 -: LW];
  assign e_pc  = sm_rdata[PCW+TIMER_W-1 -: PCW];
  assign e_tmr = $signed(sm_rdata[TIMER_W-1:0]);

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign is_last    = (slot_r == SW'(SLOT_COUNT - 1));
  assign slot_ext   = 5'(slot_r);
  assign ms_ext     = $signed(TIMER_W'(ms_r));
  assign new_sel_ok = (int'(in_slot_select) < SLOT_COUNT);
  assign prog_ok    = new_sel_ok && (int'(in_byte_address) < PROGRAM_BYTES);
  assign arg_byte   = arg_oob_r ? 8'd0 : pm_rdata;
  assign pm_waddr   = prog_addr(SW'(in_slot_select), PCW'(in_byte_address));

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    ms_nxt        = ms_r;
    buttons_nxt   = buttons_r;
    sel_nxt       = sel_r;
    sel_ok_nxt    = sel_ok_r;
    len_val_nxt   = len_val_r;
    cur_len_nxt   = cur_len_r;
    cur_pc_nxt    = cur_pc_r;
    op_nxt        = op_r;
    arg_oob_nxt   = arg_oob_r;
    out_valid_nxt = 1'b0;
    out_slot_nxt  = out_slot_r;
    out_wrote_nxt = out_wrote_r;
    out_pin_nxt   = out_pin_r;
    out_level_nxt = out_level_r;
    out_run_nxt   = out_run_r;
    out_last_nxt  = out_last_r;

    pm_we    = 1'b0;
    pm_raddr = prog_addr(slot_r, cur_pc_r);
    sm_we    = 1'b0;
    sm_waddr = slot_r;
    sm_wdata = '0;
    sm_raddr = slot_r;

    fin_en    = 1'b0;
    fin_act   = e_act;
    fin_len   = cur_len_r;
    fin_pc    = cur_pc_r;
    fin_tmr   = e_tmr;
    fin_wrote = 1'b0;
    fin_pin   = 8'd0;
    fin_level = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_PROG: begin
              pm_we = prog_ok;
            end
            ACT_LEN: begin
              // Read the slot entry now; merge the new length next cycle.
              sel_nxt     = new_sel_ok ? SW'(in_slot_select) : '0;
              sel_ok_nxt  = new_sel_ok;
              sm_raddr    = new_sel_ok ? SW'(in_slot_select) : '0;
              len_val_nxt = (int'(in_length_value) > PROGRAM_BYTES) ?
                            LW'(PROGRAM_BYTES) : LW'(in_length_value);
              state_nxt   = ST_LEN_WR;
            end
            ACT_TICK: begin
              ms_nxt      = in_tick_ms;
              buttons_nxt = in_button_levels;
              slot_nxt    = '0;
              sm_raddr    = '0;
              state_nxt   = ST_EVAL;
            end
            default: begin
            end
          endcase
        end
      end

      ST_LEN_WR: begin
        sm_we     = sel_ok_r;
        sm_waddr  = sel_r;
        sm_wdata  = {e_act, len_val_r, e_pc, e_tmr};
        state_nxt = ST_IDLE;
      end

      ST_EVAL: begin
        cur_len_nxt = e_len;
        cur_pc_nxt  = e_pc;
        fin_len     = e_len;
        fin_pc      = e_pc;
        if (!e_act) begin
          fin_en = 1'b1;
        end else if (e_pc >= PCW'(e_len)) begin
          fin_en  = 1'b1;
          fin_act = 1'b0;
        end else if (e_tmr > 0) begin
          fin_en  = 1'b1;
          fin_tmr = TIMER_W'(e_tmr - ms_ext);
        end else begin
          // Counter is below the length, so the opcode lies inside the store.
          pm_raddr  = prog_addr(slot_r, e_pc);
          state_nxt = ST_OP;
        end
      end

      ST_OP: begin
        op_nxt  = pm_rdata;
        fin_act = 1'b1;
        fin_tmr = '0;
        fin_pc  = PCW'(cur_pc_r + 1'b1);
        case (pm_rdata)
          OP_HALT: begin
            fin_en  = 1'b1;
            fin_act = 1'b0;
          end
          OP_PIN_LOW, OP_PIN_HIGH, OP_DELAY: begin
            // The operand may lie past the end of the store; it reads as zero.
            arg_oob_nxt = (int'(cur_pc_r) + 1 >= PROGRAM_BYTES);
            pm_raddr    = (int'(cur_pc_r) + 1 >= PROGRAM_BYTES) ?
                          prog_addr(slot_r, cur_pc_r) :
                          prog_addr(slot_r, PCW'(cur_pc_r + 1'b1));
            state_nxt   = ST_ARG;
          end
          default: begin
            fin_en = 1'b1;
          end
        endcase
      end

      ST_ARG: begin
        fin_en  = 1'b1;
        fin_act = 1'b1;
        fin_tmr = '0;
        fin_pc  = PCW'(cur_pc_r + 2'd2);
        case (op_r)
          OP_PIN_LOW, OP_PIN_HIGH: begin
            fin_wrote = 1'b1;
            fin_pin   = arg_byte;
            fin_level = (op_r == OP_PIN_HIGH);
          end
          OP_DELAY: begin
            fin_tmr = $signed(TIMER_W'(arg_byte) * TIMER_W'(DELAY_SCALE));
          end
          default: begin
          end
        endcase
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Button start check; an idle slot restarts from the top of its program.
    start_ok = !fin_act && (slot_ext < 5'(count_r)) &&
               (slot_ext < 5'(BUTTON_SLOTS)) && buttons_r[slot_ext[2:0]];

    if (fin_en) begin
      sm_we    = 1'b1;
      sm_waddr = slot_r;
      if (start_ok) begin
        sm_wdata = {1'b1, fin_len, PCW'(0), TIMER_W'(0)};
      end else begin
        sm_wdata = {fin_act, fin_len, fin_pc, fin_tmr};
      end
      out_valid_nxt = 1'b1;
      out_slot_nxt  = 3'(slot_r);
      out_wrote_nxt = fin_wrote;
      out_pin_nxt   = fin_pin;
      out_level_nxt = fin_level;
      out_run_nxt   = fin_act || start_ok;
      out_last_nxt  = is_last;
      if (is_last) begin
        state_nxt = ST_IDLE;
      end else begin
        // The next slot's entry is read while this one is written back.
        slot_nxt  = SW'(slot_r + 1'b1);
        sm_raddr  = SW'(slot_r + 1'b1);
        state_nxt = ST_EVAL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      sel_ok_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
      sel_ok_r    <= sel_ok_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
    end
    ms_r        <= ms_nxt;
    buttons_r   <= buttons_nxt;
    sel_r       <= sel_nxt;
    len_val_r   <= len_val_nxt;
    cur_len_r   <= cur_len_nxt;
    cur_pc_r    <= cur_pc_nxt;
    op_r        <= op_nxt;
    arg_oob_r   <= arg_oob_nxt;
    out_slot_r  <= out_slot_nxt;
    out_wrote_r <= out_wrote_nxt;
    out_pin_r   <= out_pin_nxt;
    out_level_r <= out_level_nxt;
    out_run_r   <= out_run_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_slot_index   = out_slot_r;
  assign out_pin_write    = out_wrote_r;
  assign out_pin_number   = out_pin_r;
  assign out_pin_level    = out_level_r;
  assign out_slot_running = out_run_r;
  assign out_last_result  = out_last_r;

endmodule

[rtl/tpsp_prog_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsp_prog_mem
// Program byte store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tpsp_prog_mem #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/tpsp_slot_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsp_slot_mem
// Per-slot state store with registered read. A valid bit per entry makes an
// entry that was never written since reset read as zero.
// ----------------------------------------------------------------------------
module tpsp_slot_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3,
  parameter int unsigned WIDTH = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= valid_r[raddr] ? mem[raddr] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/tpsp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsp_checker
// Port-level checks of the player's request and result timing.
// ----------------------------------------------------------------------------
module tpsp_checker
  import tpsp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_action,
  input logic       out_valid,
  input logic       out_last_result
);

  // Every result but the last of a tick is shown while the tick is in work.
  a_result_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> busy)
    else $error("non-final result outside a tick");

  // An accepted tick holds off further requests in the next cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_action == ACT_TICK) |=> busy)
    else $error("tick accepted without raising busy");

  // The first result of a tick never follows its request directly.
  a_tick_gap: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_action == ACT_TICK) |=> !out_valid)
    else $error("result right after tick request");

  // The last result of a tick stands alone.
  a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |=> !out_valid)
    else $error("result after the last result of a tick");

  // Reset leaves the block idle and silent.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

endmodule

bind triggered_pin_sequence_player tpsp_checker u_tpsp_checker (.*);

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the triggered pin sequence player. Requests are
// queued up front by a scenario block, driven by a clocked driver and mirrored
// into a behavioral model of the eight players; a clocked monitor compares
// every slot report on the result port with the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench;
  import tpsp_pkg::*;

  localparam int unsigned SLOT_COUNT    = 8;
  localparam int unsigned PROGRAM_BYTES = 256;

  // A tick keeps busy high until it has visited every slot and a length write
  // keeps busy high for one cycle, so this many quiet cycles guarantee the block
  // has settled before the routine count is rewritten or the run is closed.
  localparam int DRAIN_CYCLES = 40;

  // Action code 3 is not decoded by the block; it must be dropped silently.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Opcodes beyond the package set: a plain no-op and one undefined code.
  localparam logic [7:0] OP_NOP       = 8'd4;
  localparam logic [7:0] OP_UNDEFINED = 8'hFF;

  typedef struct packed {
    logic [1:0]  act;
    logic [2:0]  slot;
    logic [7:0]  addr;
    logic [7:0]  val;
    logic [8:0]  len;
    logic [15:0] ms;
    logic [7:0]  buttons;
  } request_t;

  // One queued entry is either a request or a write of the routine count.
  typedef struct packed {
    bit          is_cfg;
    logic [3:0]  cfg_val;
    int          gap_pct;
    request_t    req;
  } pending_t;

  typedef struct packed {
    logic [2:0] slot_index;
    logic       pin_write;
    logic [7:0] pin_number;
    logic       pin_level;
    logic       running;
    logic       last;
  } report_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_action = '0;
  logic [2:0]  in_slot_select = '0;
  logic [7:0]  in_byte_address = '0;
  logic [7:0]  in_byte_value = '0;
  logic [8:0]  in_length_value = '0;
  logic [15:0] in_tick_ms = '0;
  logic [7:0]  in_button_levels = '0;
  logic        out_valid;
  logic [2:0]  out_slot_index;
  logic        out_pin_write;
  logic [7:0]  out_pin_number;
  logic        out_pin_level;
  logic        out_slot_running;
  logic        out_last_result;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;

  triggered_pin_sequence_player #(
    .SLOT_COUNT    (SLOT_COUNT),
    .PROGRAM_BYTES (PROGRAM_BYTES)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_slot_select   (in_slot_select),
    .in_byte_address  (in_byte_address),
    .in_byte_value    (in_byte_value),
    .in_length_value  (in_length_value),
    .in_tick_ms       (in_tick_ms),
    .in_button_levels (in_button_levels),
    .out_valid        (out_valid),
    .out_slot_index   (out_slot_index),
    .out_pin_write    (out_pin_write),
    .out_pin_number   (out_pin_number),
    .out_pin_level    (out_pin_level),
    .out_slot_running (out_slot_running),
    .out_last_result  (out_last_result),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run of the scenario below.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Behavioral model of the players. It is updated by the driver at the edge
  // that accepts each request, so its state always matches the block's view.
  // --------------------------------------------------------------------------
  logic [7:0] prog_img  [SLOT_COUNT][PROGRAM_BYTES];
  logic [8:0] len_img   [SLOT_COUNT];
  logic [8:0] pc_img    [SLOT_COUNT];
  bit         run_img   [SLOT_COUNT];
  int         timer_img [SLOT_COUNT];
  logic [3:0] count_img;

  report_t  reports_due[$];
  pending_t request_fifo[$];
  int       mismatch_count = 0;

  // Reads the byte under the program counter and steps past it. Positions
  // beyond the store read as zero.
  function automatic logic [7:0] fetch_next(int s);
    logic [8:0] pos;
    pos = pc_img[s];
    pc_img[s] = pos + 9'd1;
    if (pos >= PROGRAM_BYTES) return 8'd0;
    return prog_img[s][pos[7:0]];
  endfunction

  // Applies one accepted request; a tick queues one report per slot.
  task automatic play_request(request_t r);
    report_t    rep;
    logic [7:0] op;
    case (r.act)
      ACT_PROG: prog_img[r.slot][r.addr] = r.val;
      ACT_LEN:  len_img[r.slot] = (r.len > PROGRAM_BYTES) ? 9'(PROGRAM_BYTES) : r.len;
      ACT_TICK: begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
          rep = '0;
          if (run_img[s]) begin
            if (pc_img[s] >= len_img[s]) begin
              // Ran off the end of the routine.
              run_img[s] = 1'b0;
            end else if (timer_img[s] > 0) begin
              // Still waiting; the timer may overshoot below zero.
              timer_img[s] -= int'(r.ms);
            end else begin
              op = fetch_next(s);
              if (op == OP_HALT) begin
                run_img[s] = 1'b0;
              end else if (op == OP_PIN_LOW || op == OP_PIN_HIGH) begin
                // The operand is fetched even when it lies past the length.
                rep.pin_number = fetch_next(s);
                rep.pin_write  = 1'b1;
                rep.pin_level  = (op == OP_PIN_HIGH);
              end else if (op == OP_DELAY) begin
                timer_img[s] = int'(fetch_next(s)) * DELAY_SCALE;
              end
              // Every other opcode is a no-op.
            end
          end
          // An idle slot within the routine count starts on its button.
          if (!run_img[s] && s < count_img && s < BUTTON_SLOTS && r.buttons[s]) begin
            run_img[s]   = 1'b1;
            pc_img[s]    = '0;
            timer_img[s] = 0;
          end
          rep.slot_index = 3'(s);
          rep.running    = run_img[s];
          rep.last       = (s == SLOT_COUNT - 1);
          reports_due.push_back(rep);
        end
      end
      default: ;
    endcase
  endtask

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic string report_text(report_t r);
    return $sformatf("slot %0d write %0b pin %0d level %0b running %0b last %0b",
                     r.slot_index, r.pin_write, r.pin_number, r.pin_level,
                     r.running, r.last);
  endfunction

  // --------------------------------------------------------------------------
  // Driver. Everything is decided with blocking temporaries and each port
  // gets a single nonblocking assignment per edge, so start can stay high
  // across back-to-back requests. Routine count writes wait until the block
  // has been quiet for DRAIN_CYCLES and no report is outstanding.
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin : drive_requests
    pending_t head;
    request_t on_port;
    bit       took;
    bit       nxt_start;
    bit       nxt_we;
    if (!rst_n) begin
      start  <= 1'b0;
      cfg_we <= 1'b0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        len_img[s]   = '0;
        pc_img[s]    = '0;
        run_img[s]   = 1'b0;
        timer_img[s] = 0;
      end
      count_img    = '0;
      quiet_cycles = 0;
    end else begin
      took = start && !busy;
      if (took) begin
        on_port = '{in_action, in_slot_select, in_byte_address, in_byte_value,
                    in_length_value, in_tick_ms, in_button_levels};
        play_request(on_port);
        quiet_cycles = 0;
      end else if (!start && !cfg_we && quiet_cycles < DRAIN_CYCLES) begin
        quiet_cycles++;
      end

      nxt_start = start && !took;
      nxt_we    = 1'b0;
      if (!nxt_start && request_fifo.size() != 0) begin
        head = request_fifo[0];
        if (head.is_cfg) begin
          if (!start && !cfg_we && quiet_cycles >= DRAIN_CYCLES &&
              reports_due.size() == 0) begin
            nxt_we       = 1'b1;
            cfg_wdata    <= head.cfg_val;
            count_img    = head.cfg_val;
            quiet_cycles = 0;
            void'(request_fifo.pop_front());
          end
        end else if ($urandom_range(99) >= head.gap_pct) begin
          nxt_start        = 1'b1;
          in_action        <= head.req.act;
          in_slot_select   <= head.req.slot;
          in_byte_address  <= head.req.addr;
          in_byte_value    <= head.req.val;
          in_length_value  <= head.req.len;
          in_tick_ms       <= head.req.ms;
          in_button_levels <= head.req.buttons;
          void'(request_fifo.pop_front());
        end
      end
      start  <= nxt_start;
      cfg_we <= nxt_we;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Reports cannot be held off, so each strobe is consumed at the
  // edge that ends its cycle and checked against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_reports
    report_t seen;
    report_t want;
    if (rst_n && out_valid) begin
      seen = '{out_slot_index, out_pin_write, out_pin_number, out_pin_level,
               out_slot_running, out_last_result};
      if (reports_due.size() == 0) begin
        note_mismatch({"unexpected report: ", report_text(seen)});
      end else begin
        want = reports_due.pop_front();
        if (seen !== want)
          note_mismatch({"expected ", report_text(want), " got ", report_text(seen)});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus construction. The scenario keeps its own record of which program
  // bytes have been loaded: a length is only ever set after every byte that a
  // routine of that length can fetch, including a trailing operand, has been
  // written, so the block never reads an unwritten program byte.
  // --------------------------------------------------------------------------
  bit byte_loaded [SLOT_COUNT][PROGRAM_BYTES];
  int phase_gap_pct   = 0;
  int requests_queued = 0;

  function automatic request_t random_request(logic [1:0] act);
    request_t r;
    r.act     = act;
    r.slot    = 3'($urandom);
    r.addr    = 8'($urandom);
    r.val     = 8'($urandom);
    r.len     = 9'($urandom);
    r.ms      = 16'($urandom);
    r.buttons = 8'($urandom);
    return r;
  endfunction

  task automatic queue_request(request_t r);
    pending_t e;
    e.is_cfg  = 1'b0;
    e.cfg_val = '0;
    e.gap_pct = phase_gap_pct;
    e.req     = r;
    request_fifo.push_back(e);
    if (r.act == ACT_PROG) byte_loaded[r.slot][r.addr] = 1'b1;
    // Dropped requests do not count toward the stimulus volume.
    if (r.act != ACT_UNUSED) requests_queued++;
  endtask

  task automatic queue_config(logic [3:0] value);
    pending_t e;
    e.is_cfg  = 1'b1;
    e.cfg_val = value;
    e.gap_pct = phase_gap_pct;
    e.req     = random_request(ACT_TICK);
    request_fifo.push_back(e);
  endtask

  task automatic queue_write(logic [2:0] slot, logic [7:0] addr, logic [7:0] val);
    request_t r;
    r      = random_request(ACT_PROG);
    r.slot = slot;
    r.addr = addr;
    r.val  = val;
    queue_request(r);
  endtask

  task automatic queue_tick(logic [15:0] ms, logic [7:0] buttons);
    request_t r;
    r         = random_request(ACT_TICK);
    r.ms      = ms;
    r.buttons = buttons;
    queue_request(r);
  endtask

  // Mostly real opcodes, with a tail of arbitrary bytes that serve as pin
  // numbers, delay counts and undefined opcodes.
  function automatic logic [7:0] routine_byte();
    int r;
    r = $urandom_range(99);
    if (r < 6)  return OP_HALT;
    if (r < 28) return OP_PIN_LOW;
    if (r < 50) return OP_PIN_HIGH;
    if (r < 60) return OP_DELAY;
    if (r < 72) return OP_NOP;
    return 8'($urandom);
  endfunction

  task automatic queue_length(logic [2:0] slot, logic [8:0] lv);
    request_t r;
    int       top;
    top = (lv > PROGRAM_BYTES - 1) ? PROGRAM_BYTES - 1 : lv;
    for (int a = 0; a <= top; a++)
      if (!byte_loaded[slot][a]) queue_write(slot, 8'(a), routine_byte());
    r      = random_request(ACT_LEN);
    r.slot = slot;
    r.len  = lv;
    queue_request(r);
  endtask

  // Fresh routine: every byte it may fetch is rewritten, then the length.
  task automatic load_routine(logic [2:0] slot, int len);
    for (int a = 0; a <= len; a++) queue_write(slot, 8'(a), routine_byte());
    queue_length(slot, 9'(len));
  endtask

  function automatic logic [15:0] pick_ms();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'hFFFF;
    if (r < 40) return 16'($urandom_range(1, 3000));
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_buttons();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 8'h00;
    if (r < 25) return 8'hFF;
    return 8'($urandom);
  endfunction

  // Mostly ticks and short routine loads, with stray writes, bare length
  // changes on live slots and dropped requests mixed in.
  task automatic random_mix(int count);
    int base;
    int r;
    base = requests_queued;
    while (requests_queued - base < count) begin
      r = $urandom_range(99);
      if (r < 60)      queue_tick(pick_ms(), pick_buttons());
      else if (r < 75) load_routine(3'($urandom), $urandom_range(0, 12));
      else if (r < 85) queue_write(3'($urandom), 8'($urandom), 8'($urandom));
      else if (r < 93) queue_length(3'($urandom), 9'($urandom_range(0, 16)));
      else             queue_request(random_request(ACT_UNUSED));
    end
  endtask

  initial begin : scenario
    request_t   r;
    logic [7:0] op;

    // Directed opening, no sender gaps. Slot 0 walks through a pin high on
    // the top pin number, a one second delay that a full-scale tick drives
    // negative, an undefined opcode and a halt. Slot 1 has length one, so
    // its pin low takes its operand from past the end of the routine.
    phase_gap_pct = 0;
    queue_config(4'd8);
    queue_write(3'd0, 8'd0, OP_PIN_HIGH);
    queue_write(3'd0, 8'd1, 8'hFF);
    queue_write(3'd0, 8'd2, OP_DELAY);
    queue_write(3'd0, 8'd3, 8'd1);
    queue_write(3'd0, 8'd4, OP_UNDEFINED);
    queue_write(3'd0, 8'd5, OP_HALT);
    queue_write(3'd0, 8'd6, OP_NOP);
    queue_length(3'd0, 9'd6);
    queue_write(3'd1, 8'd0, OP_PIN_LOW);
    queue_write(3'd1, 8'd1, 8'h00);
    queue_length(3'd1, 9'd1);
    queue_write(3'd7, 8'hFF, 8'hFF);
    r = '{ACT_UNUSED, 3'h7, 8'hFF, 8'hFF, 9'h1FF, 16'hFFFF, 8'hFF};
    queue_request(r);
    queue_tick(16'd0, 8'hFF);
    queue_tick(16'd0, 8'h00);
    queue_tick(16'hFFFF, 8'h00);
    queue_tick(16'hFFFF, 8'h00);
    queue_tick(16'd0, 8'h00);
    queue_tick(16'd0, 8'h00);
    queue_tick(16'd0, 8'h01);
    queue_length(3'd0, 9'd0);
    queue_tick(16'd0, 8'h01);

    // Full-size routine on slot 7 with an oversized length that saturates.
    // Bytes pair up so that the last position holds a pin high whose operand
    // lies beyond the store. Its delays last zero seconds, so every tick
    // moves it on by one pair and the walk reaches the end of the store in
    // about 130 ticks. A routine count above the slot count lets every slot
    // start.
    phase_gap_pct = 0;
    queue_config(4'd15);
    for (int p = 0; p < PROGRAM_BYTES - 2; p += 2) begin
      case ($urandom_range(2))
        0:       op = OP_PIN_LOW;
        1:       op = OP_PIN_HIGH;
        default: op = OP_DELAY;
      endcase
      queue_write(3'd7, 8'(p), op);
      queue_write(3'd7, 8'(p + 1), (op == OP_DELAY) ? 8'd0 : 8'($urandom));
    end
    queue_write(3'd7, 8'd254, OP_NOP);
    queue_write(3'd7, 8'd255, OP_PIN_HIGH);
    queue_length(3'd7, 9'h1FF);
    queue_tick(pick_ms(), 8'h80);
    repeat (135) queue_tick(pick_ms(), pick_buttons());

    // Random phases: heavy sender gaps, a routine count of zero, then
    // moderate gaps.
    phase_gap_pct = 52;
    queue_config(4'd3);
    random_mix(30);
    phase_gap_pct = 0;
    queue_config(4'd0);
    random_mix(10);
    phase_gap_pct = 27;
    queue_config(4'd8);
    random_mix(30);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Sampling on the falling edge keeps this loop clear of the clocked
    // blocks' updates.
    do @(negedge clk);
    while (request_fifo.size() != 0 || start || busy || reports_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (reports_due.size() != 0)
      note_mismatch($sformatf("%0d slot reports never arrived", reports_due.size()));
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[triggered_pin_sequence_player.f]
rtl/tpsp_pkg.sv
rtl/tpsp_prog_mem.sv
rtl/tpsp_slot_mem.sv
rtl/triggered_pin_sequence_player.sv
rtl/tpsp_checker.sv
sim/testbench.sv
